@@ sv/grid_maze_dfs_solver_assert.svh @@
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver_assert.svh
// Assertion macros shared by the maze solver modules. They expect a clock
// named clk and a synchronous active-high reset named rst in scope.
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_DFS_SOLVER_ASSERT_SVH
`define GRID_MAZE_DFS_SOLVER_ASSERT_SVH

// same-cycle implication
`define GMDS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gmds_pkg.sv @@
// ----------------------------------------------------------------------------
// gmds_pkg
// Types, codes and defaults shared by the grid maze solver modules.
// ----------------------------------------------------------------------------
package gmds_pkg;

  localparam int GMDS_GRID_SIZE = 8;

  localparam logic [2:0] MARK_EMPTY = 3'd0;
  localparam logic [2:0] MARK_BLOCK = 3'd1;
  localparam logic [2:0] MARK_START = 3'd2;
  localparam logic [2:0] MARK_END   = 3'd3;
  localparam logic [2:0] MARK_PATH  = 3'd4;
  localparam logic [2:0] MARK_DEAD  = 3'd5;

  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_DONE  = 3'd4;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_LOOK,
    ST_ENTER,
    ST_STEP,
    ST_POP_LD,
    ST_DONE,
    ST_RDOUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SWEEP,
    OP_LOOK,
    OP_ENTER,
    OP_STEP,
    OP_POP,
    OP_POP_LOAD,
    OP_OUT_RUN,
    OP_OUT_READ
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic start_inside;
    logic enter_end;
    logic sp_zero;
    logic sp_last;
    logic dir_done;
    logic nbr_ok;
    logic out_busy;
  } sts_t;

endpackage

@@ sv/gmds_ram.sv @@
// ----------------------------------------------------------------------------
// gmds_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module gmds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/gmds_ctrl.sv @@
// ----------------------------------------------------------------------------
// gmds_ctrl
// Control FSM: sequences item handling, the mark sweep, and the depth-first
// walk (step, enter, pop), one datapath operation per cycle unless stalled.
// ----------------------------------------------------------------------------
module gmds_ctrl import gmds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action_t'(action))
            ACT_RUN:  state_next = ST_SWEEP;
            ACT_READ: state_next = ST_RDOUT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sts.sweep_done) begin
          state_next = sts.start_inside ? ST_LOOK : ST_DONE;
        end
      end
      ST_LOOK:  state_next = ST_ENTER;
      ST_ENTER: state_next = sts.enter_end ? ST_DONE : ST_STEP;
      ST_STEP: begin
        if (sts.sp_zero) begin
          state_next = ST_DONE;
        end else if (sts.dir_done) begin
          state_next = sts.sp_last ? ST_STEP : ST_POP_LD;
        end else begin
          state_next = sts.nbr_ok ? ST_ENTER : ST_STEP;
        end
      end
      ST_POP_LD: state_next = ST_STEP;
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    cmd.op   = OP_NONE;
    case (state)
      ST_IDLE:   cmd.op = in_valid ? OP_ACCEPT : OP_NONE;
      ST_SWEEP:  cmd.op = OP_SWEEP;
      ST_LOOK:   cmd.op = OP_LOOK;
      ST_ENTER:  cmd.op = OP_ENTER;
      ST_STEP: begin
        if (sts.sp_zero) begin
          cmd.op = OP_NONE;
        end else if (sts.dir_done) begin
          cmd.op = OP_POP;
        end else begin
          cmd.op = OP_STEP;
        end
      end
      ST_POP_LD: cmd.op = OP_POP_LOAD;
      ST_DONE:   cmd.op = sts.out_busy ? OP_NONE : OP_OUT_RUN;
      ST_RDOUT:  cmd.op = sts.out_busy ? OP_NONE : OP_OUT_READ;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ sv/gmds_dp.sv @@
// ----------------------------------------------------------------------------
// gmds_dp
// Datapath: grid mark memory with per-cell valid bits, walk stack memory with
// the top entry held in registers, neighbor generation, and result register.
// ----------------------------------------------------------------------------
`include "grid_maze_dfs_solver_assert.svh"

module gmds_dp import gmds_pkg::*; #(
  parameter int GRID_SIZE = GMDS_GRID_SIZE
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [1:0] action,
  input  logic [2:0] row,
  input  logic [2:0] column,
  input  logic [1:0] cell_kind,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [2:0] cell_mark
);

  localparam int CW          = $clog2(GRID_SIZE);
  localparam int CELL_COUNT  = GRID_SIZE * GRID_SIZE;
  localparam int IW          = $clog2(CELL_COUNT);
  localparam int SCW         = $clog2(CELL_COUNT + 1);
  localparam int STACK_DEPTH = CELL_COUNT + 4;
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int SPW         = $clog2(STACK_DEPTH + 1);
  localparam int SEW         = 2 * CW + 4;
  localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

  function automatic logic [IW-1:0] cell_idx(input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
    return IW'(int'(r) * GRID_SIZE + int'(c));
  endfunction

  // grid memory ports
  logic            g_we, g_re;
  logic [IW-1:0]   g_waddr, g_raddr;
  logic [2:0]      g_wdata, g_rdata;
  // stack memory ports
  logic            s_we, s_re;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [SEW-1:0]  s_wdata, s_rdata;

  logic [CELL_COUNT-1:0] valid;
  logic                  rd_vld;
  logic [2:0]            mark_q;

  logic [CW-1:0]  run_row, run_col;
  logic           run_inside, item_inside;
  logic [SCW-1:0] sweep_cnt, sweep_prev;
  logic [SPW-1:0] sp, sp_m1, sp_m2;
  logic [CW-1:0]  top_row, top_col, nbr_row, nbr_col, cand_row, cand_col;
  logic [2:0]     top_dir;
  logic           top_start;
  logic           found_q;

  action_t        act;
  logic           in_inside;
  logic [IW-1:0]  in_idx;
  logic           nbr_ok, sweep_done, sp_full, from_start;
  logic           is_empty, is_start, is_end, enter_end, enter_push;

  assign act        = action_t'(action);
  assign in_inside  = (int'(row) < GRID_SIZE) && (int'(column) < GRID_SIZE);
  assign in_idx     = cell_idx(CW'(row), CW'(column));
  assign mark_q     = rd_vld ? g_rdata : MARK_EMPTY;
  assign sweep_done = (sweep_cnt == SCW'(CELL_COUNT));
  assign sweep_prev = sweep_cnt - 1'b1;
  assign sp_m1      = sp - 1'b1;
  assign sp_m2      = sp - SPW'(2);
  assign sp_full    = (sp >= SPW'(STACK_DEPTH));
  assign from_start = (sp != '0) && top_start;

  assign is_empty   = (mark_q == MARK_EMPTY);
  assign is_start   = (mark_q == MARK_START);
  assign is_end     = (mark_q == MARK_END);
  assign enter_end  = is_end;
  assign enter_push = (is_empty || is_start) && !(is_start && from_start) && !sp_full;

  always_comb begin
    cand_row = top_row;
    cand_col = top_col;
    nbr_ok   = 1'b0;
    case (top_dir)
      DIR_UP: begin
        nbr_ok   = (top_row != '0);
        cand_row = top_row - 1'b1;
      end
      DIR_RIGHT: begin
        nbr_ok   = (top_col != LAST);
        cand_col = top_col + 1'b1;
      end
      DIR_DOWN: begin
        nbr_ok   = (top_row != LAST);
        cand_row = top_row + 1'b1;
      end
      DIR_LEFT: begin
        nbr_ok   = (top_col != '0);
        cand_col = top_col - 1'b1;
      end
      default: nbr_ok = 1'b0;
    endcase
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = MARK_EMPTY;
    g_re    = 1'b0;
    g_raddr = '0;
    case (cmd.op)
      OP_ACCEPT: begin
        case (act)
          ACT_WRITE: begin
            g_we    = in_inside;
            g_waddr = in_idx;
            g_wdata = {1'b0, cell_kind};
          end
          ACT_READ: begin
            g_re    = 1'b1;
            g_raddr = in_idx;
          end
          default: g_re = 1'b0;
        endcase
      end
      OP_SWEEP: begin
        g_re    = !sweep_done;
        g_raddr = sweep_cnt[IW-1:0];
        g_we    = (sweep_cnt != '0) && ((mark_q == MARK_PATH) || (mark_q == MARK_DEAD));
        g_waddr = sweep_prev[IW-1:0];
        g_wdata = MARK_EMPTY;
      end
      OP_LOOK: begin
        g_re    = 1'b1;
        g_raddr = cell_idx(run_row, run_col);
      end
      OP_STEP: begin
        g_re    = nbr_ok;
        g_raddr = cell_idx(cand_row, cand_col);
      end
      OP_ENTER: begin
        g_we    = enter_push && is_empty;
        g_waddr = cell_idx(nbr_row, nbr_col);
        g_wdata = MARK_PATH;
      end
      OP_POP: begin
        g_we    = !top_start;
        g_waddr = cell_idx(top_row, top_col);
        g_wdata = MARK_DEAD;
      end
      default: g_re = 1'b0;
    endcase
  end

  assign s_we    = (cmd.op == OP_ENTER) && !enter_end && enter_push && (sp != '0);
  assign s_waddr = sp_m1[SAW-1:0];
  assign s_wdata = {top_row, top_col, top_dir, top_start};
  assign s_re    = (cmd.op == OP_POP) && (sp > SPW'(1));
  assign s_raddr = sp_m2[SAW-1:0];

  gmds_ram #(
    .WIDTH (3),
    .DEPTH (CELL_COUNT)
  ) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  gmds_ram #(
    .WIDTH (SEW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // valid bits: a cell never written since reset or clear reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if ((cmd.op == OP_ACCEPT) && (act == ACT_CLEAR)) begin
      valid <= '0;
    end else if (g_we) begin
      valid[g_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (g_re) begin
      rd_vld <= valid[g_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          if ((act == ACT_RUN) || (act == ACT_CLEAR)) begin
            sp <= '0;
          end
        end
        OP_ENTER: begin
          if (!enter_end && enter_push) begin
            sp <= sp + 1'b1;
          end
        end
        OP_POP:  sp <= sp_m1;
        default: sp <= sp;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        item_inside <= in_inside;
        if (act == ACT_RUN) begin
          run_row    <= CW'(row);
          run_col    <= CW'(column);
          run_inside <= in_inside;
          sweep_cnt  <= '0;
          found_q    <= 1'b0;
        end
      end
      OP_SWEEP: sweep_cnt <= sweep_cnt + 1'b1;
      OP_LOOK: begin
        nbr_row <= run_row;
        nbr_col <= run_col;
      end
      OP_STEP: begin
        top_dir <= top_dir + 1'b1;
        if (nbr_ok) begin
          nbr_row <= cand_row;
          nbr_col <= cand_col;
        end
      end
      OP_ENTER: begin
        if (enter_end) begin
          found_q <= 1'b1;
        end else if (enter_push) begin
          top_row   <= nbr_row;
          top_col   <= nbr_col;
          top_dir   <= DIR_UP;
          top_start <= is_start;
        end
      end
      OP_POP_LOAD: {top_row, top_col, top_dir, top_start} <= s_rdata;
      default: found_q <= found_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.op == OP_OUT_RUN) || (cmd.op == OP_OUT_READ)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_RUN) begin
      found     <= found_q;
      cell_mark <= MARK_EMPTY;
    end else if (cmd.op == OP_OUT_READ) begin
      found     <= 1'b0;
      cell_mark <= item_inside ? mark_q : MARK_EMPTY;
    end
  end

  assign sts.sweep_done   = sweep_done;
  assign sts.start_inside = run_inside;
  assign sts.enter_end    = enter_end;
  assign sts.sp_zero      = (sp == '0);
  assign sts.sp_last      = (sp == SPW'(1));
  assign sts.dir_done     = (top_dir == DIR_DONE);
  assign sts.nbr_ok       = nbr_ok;
  assign sts.out_busy     = out_valid && out_stall;

  `GMDS_ASSERT_IMPL(a_sp_range, 1'b1, sp <= SPW'(STACK_DEPTH), "stack pointer past depth")
  `GMDS_ASSERT_IMPL(a_pop_nonempty, cmd.op == OP_POP, sp != '0, "pop on empty stack")
  `GMDS_ASSERT_NEXT(a_push_grows, (cmd.op == OP_ENTER) && !enter_end && enter_push, sp == $past(sp) + 1'b1, "push did not advance stack")
  `GMDS_ASSERT_NEXT(a_pop_shrinks, cmd.op == OP_POP, sp == $past(sp) - 1'b1, "pop did not retire entry")
  `GMDS_ASSERT_IMPL(a_no_rw_clash, g_we && g_re, g_waddr != g_raddr, "grid read and write collide")

endmodule

@@ sv/grid_maze_dfs_solver.sv @@
// Write and clear give no result and leave the block idle; a read registers the grid
// data, then loads it into the result register. A run sweeps the grid memory, loads
// the start cell, then walks: a direction off the grid only steps on, a neighbor takes
// a registered grid read and an enter, a backtrack a pop and a top reload (none for the
// last), then a result load. One item at a time; the result register frees the input.
// Reset (synchronous): grid reads as all empty at once via per-cell valid bits.
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver
// Grid maze loader and depth-first search solver: controller plus datapath.
// ----------------------------------------------------------------------------
module grid_maze_dfs_solver import gmds_pkg::*; #(
  parameter int GRID_SIZE = GMDS_GRID_SIZE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [2:0] row,
  input  logic [2:0] column,
  input  logic [1:0] cell_kind,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [2:0] cell_mark
);

  cmd_t cmd;
  sts_t sts;

  gmds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gmds_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .action    (action),
    .row       (row),
    .column    (column),
    .cell_kind (cell_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .cell_mark (cell_mark)
  );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid maze solver. A queue of maze loads,
// searches and mark reads drives the block through valid/stall with random
// gaps and stalls; an in-bench depth-first model predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import gmds_pkg::*;

  localparam int SIDE        = GMDS_GRID_SIZE;
  localparam int CELLS       = SIDE * SIDE;
  localparam int TRAIL_DEPTH = CELLS + 4;

  localparam logic [1:0] KIND_EMPTY = MARK_EMPTY[1:0];
  localparam logic [1:0] KIND_BLOCK = MARK_BLOCK[1:0];
  localparam logic [1:0] KIND_START = MARK_START[1:0];
  localparam logic [1:0] KIND_END   = MARK_END[1:0];

  typedef struct {
    action_t    act;
    logic [2:0] r;
    logic [2:0] c;
    logic [1:0] kind;
    bit         drain;
  } maze_item_t;

  typedef struct {
    logic       found;
    logic [2:0] mark;
  } answer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = ACT_WRITE;
  logic [2:0] row = 3'd0;
  logic [2:0] column = 3'd0;
  logic [1:0] cell_kind = KIND_EMPTY;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       found;
  logic [2:0] cell_mark;

  grid_maze_dfs_solver u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .row       (row),
    .column    (column),
    .cell_kind (cell_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .cell_mark (cell_mark)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // maze model
  logic [2:0] maze [CELLS];
  logic [5:0] trail_spot [TRAIL_DEPTH];
  logic [2:0] trail_dir [TRAIL_DEPTH];
  int         trail_len;

  maze_item_t item_q [$];
  answer_t    answer_q [$];
  maze_item_t cur_item;
  int         item_total;
  int         sent_count;
  int         err_count;
  int         run_count;
  int         hit_count;
  int         read_count;
  int         deepest_walk;
  int         full_refusals;
  int         gap_left;
  int         stall_left;
  bit         calm_in;
  bit         calm_out;

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic bit step_into(int spot, bit from_start);
    logic [2:0] m;
    m = maze[spot];
    if (m != MARK_EMPTY && m != MARK_START && m != MARK_END) return 1'b0;
    if (m == MARK_START && from_start) return 1'b0;
    if (m == MARK_END) return 1'b1;
    if (trail_len >= TRAIL_DEPTH) begin
      full_refusals++;
      return 1'b0;
    end
    if (m == MARK_EMPTY) maze[spot] = MARK_PATH;
    trail_spot[trail_len] = 6'(spot);
    trail_dir[trail_len] = DIR_UP;
    trail_len++;
    if (trail_len > deepest_walk) deepest_walk = trail_len;
    return 1'b0;
  endfunction

  function automatic bit solve_maze(logic [2:0] r0, logic [2:0] c0);
    int         top;
    int         here;
    int         r;
    int         c;
    logic [2:0] d;
    bit         ok;
    for (int i = 0; i < CELLS; i++)
      if (maze[i] == MARK_PATH || maze[i] == MARK_DEAD) maze[i] = MARK_EMPTY;
    trail_len = 0;
    if (step_into(int'(r0) * SIDE + int'(c0), 1'b0)) return 1'b1;
    while (trail_len > 0) begin
      top = trail_len - 1;
      here = trail_spot[top];
      d = trail_dir[top];
      if (d >= DIR_DONE) begin
        trail_len = top;
        if (maze[here] == MARK_PATH) maze[here] = MARK_DEAD;
        continue;
      end
      trail_dir[top] = d + 3'd1;
      r = here / SIDE;
      c = here % SIDE;
      ok = 1'b1;
      case (d)
        DIR_UP: begin
          if (r == 0) ok = 1'b0; else r--;
        end
        DIR_RIGHT: begin
          if (c + 1 >= SIDE) ok = 1'b0; else c++;
        end
        DIR_DOWN: begin
          if (r + 1 >= SIDE) ok = 1'b0; else r++;
        end
        default: begin
          if (c == 0) ok = 1'b0; else c--;
        end
      endcase
      if (!ok) continue;
      if (step_into(r * SIDE + c, maze[here] == MARK_START)) begin
        trail_len = 0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic apply_item(maze_item_t it);
    answer_t a;
    int      idx;
    idx = int'(it.r) * SIDE + int'(it.c);
    a.found = 1'b0;
    a.mark = MARK_EMPTY;
    case (it.act)
      ACT_WRITE: maze[idx] = {1'b0, it.kind};
      ACT_RUN: begin
        a.found = solve_maze(it.r, it.c);
        run_count++;
        if (a.found) hit_count++;
        answer_q.push_back(a);
      end
      ACT_READ: begin
        a.mark = maze[idx];
        read_count++;
        answer_q.push_back(a);
      end
      default: begin
        for (int i = 0; i < CELLS; i++) maze[i] = MARK_EMPTY;
        trail_len = 0;
      end
    endcase
  endtask

  task automatic add_item(action_t act, logic [2:0] r, logic [2:0] c,
                          logic [1:0] kind, bit drain = 1'b0);
    maze_item_t it;
    it.act = act;
    it.r = r;
    it.c = c;
    it.kind = kind;
    it.drain = drain || ($urandom_range(0, 39) == 0);
    item_q.push_back(it);
  endtask

  task automatic add_maze();
    logic [2:0] sr;
    logic [2:0] sc;
    int         walls;
    if ($urandom_range(0, 3) != 0) add_item(ACT_CLEAR, 3'($urandom), 3'($urandom), 2'($urandom));
    walls = $urandom_range(4, 30);
    repeat (walls) begin
      if ($urandom_range(0, 7) == 0)
        add_item(ACT_WRITE, 3'($urandom), 3'($urandom), 2'($urandom));
      else
        add_item(ACT_WRITE, 3'($urandom), 3'($urandom), KIND_BLOCK);
    end
    sr = 3'($urandom);
    sc = 3'($urandom);
    add_item(ACT_WRITE, sr, sc, KIND_START);
    if ($urandom_range(0, 4) != 0)
      add_item(ACT_WRITE, 3'($urandom), 3'($urandom), KIND_END);
    add_item(ACT_RUN, sr, sc, 2'($urandom));
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) != 0)
        add_item(ACT_WRITE, 3'($urandom), 3'($urandom), 2'($urandom));
      add_item(ACT_RUN, 3'($urandom), 3'($urandom), 2'($urandom));
    end
    repeat ($urandom_range(2, 6))
      add_item(ACT_READ, 3'($urandom), 3'($urandom), 2'($urandom));
  endtask

  // dense start cells exercise re-entry of start cells and the stack bound
  task automatic add_start_field();
    add_item(ACT_CLEAR, 3'd0, 3'd0, KIND_EMPTY);
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        if ((r + c) % 2 == 0 && $urandom_range(0, 3) != 0)
          add_item(ACT_WRITE, 3'(r), 3'(c), KIND_START);
    add_item(ACT_WRITE, 3'($urandom), 3'($urandom), KIND_END);
    add_item(ACT_RUN, 3'd0, 3'd0, KIND_EMPTY);
    add_item(ACT_RUN, 3'($urandom), 3'($urandom), KIND_EMPTY);
    repeat (4) add_item(ACT_READ, 3'($urandom), 3'($urandom), 2'($urandom));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_item(cur_item);
        sent_count++;
        gap_left = calm_in ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_q.size() != 0 && !(item_q[0].drain && answer_q.size() != 0)) begin
          cur_item = item_q.pop_front();
          action <= cur_item.act;
          row <= cur_item.r;
          column <= cur_item.c;
          cell_kind <= cur_item.kind;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (found %0b mark %0d)",
                                    found, cell_mark));
        end else begin
          want = answer_q.pop_front();
          if (found !== want.found)
            report_mismatch($sformatf("found %0b, predicted %0b", found, want.found));
          if (cell_mark !== want.mark)
            report_mismatch($sformatf("cell_mark %0d, predicted %0d", cell_mark, want.mark));
        end
        stall_left = calm_out ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
      end
      if (stall_left > 0 && (out_valid || $urandom_range(0, 1) != 0)) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int pick;
    for (int i = 0; i < CELLS; i++) maze[i] = MARK_EMPTY;
    trail_len = 0;

    add_item(ACT_READ, 3'd0, 3'd0, KIND_EMPTY);
    add_item(ACT_WRITE, 3'd7, 3'd7, KIND_END);
    add_item(ACT_WRITE, 3'd0, 3'd0, KIND_START);
    add_item(ACT_WRITE, 3'd0, 3'd7, KIND_BLOCK);
    add_item(ACT_READ, 3'd7, 3'd7, KIND_EMPTY);
    add_item(ACT_READ, 3'd0, 3'd7, KIND_BLOCK);
    add_item(ACT_RUN, 3'd0, 3'd0, KIND_END);
    add_item(ACT_READ, 3'd0, 3'd1, KIND_START, 1'b1);
    add_item(ACT_RUN, 3'd0, 3'd7, KIND_EMPTY);
    add_item(ACT_RUN, 3'd7, 3'd7, KIND_EMPTY);
    add_item(ACT_WRITE, 3'd6, 3'd7, KIND_BLOCK);
    add_item(ACT_WRITE, 3'd7, 3'd6, KIND_BLOCK);
    add_item(ACT_RUN, 3'd0, 3'd0, KIND_EMPTY);
    add_item(ACT_READ, 3'd3, 3'd3, KIND_EMPTY);
    add_item(ACT_READ, 3'd7, 3'd7, KIND_EMPTY);
    add_item(ACT_WRITE, 3'd0, 3'd1, KIND_START);
    add_item(ACT_WRITE, 3'd1, 3'd0, KIND_START);
    add_item(ACT_RUN, 3'd0, 3'd1, KIND_EMPTY);
    add_item(ACT_READ, 3'd1, 3'd1, KIND_EMPTY);
    add_item(ACT_RUN, 3'd4, 3'd4, KIND_EMPTY);
    add_item(ACT_WRITE, 3'd7, 3'd6, KIND_EMPTY);
    add_item(ACT_RUN, 3'd4, 3'd4, KIND_EMPTY);
    add_item(ACT_CLEAR, 3'd7, 3'd7, KIND_END);
    add_item(ACT_READ, 3'd7, 3'd7, KIND_EMPTY);
    add_item(ACT_READ, 3'd0, 3'd0, KIND_EMPTY);

    while (item_q.size() < 420) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        add_maze();
      end else if (pick < 8) begin
        add_start_field();
      end else begin
        repeat (5)
          add_item(action_t'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                   2'($urandom));
      end
    end
    item_total = item_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (sent_count < item_total) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d items: %0d searches (%0d reached an end cell), %0d mark reads.",
             item_total, run_count, hit_count, read_count);
    $display("Deepest walk held %0d cells; %0d entries refused on a full stack.",
             deepest_walk, full_refusals);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
